/* sv/gose_pkg.sv */
// ----------------------------------------------------------------------------
// gose_pkg
// Shared widths, control word layout and the microprogram of the glycolysis
// oscillator Euler stepper.
// ----------------------------------------------------------------------------
package gose_pkg;

  // Number format of the concentrations (unsigned Q8.24 in 32 bits).
  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 24;
  localparam int REPORT_INTERVAL_DEF = 100;

  // Request operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register widths and reset values.
  localparam int NU_W = 28;
  localparam int DT_W = 25;
  localparam logic [NU_W-1:0] NU_RESET = NU_W'(16777216);
  localparam logic [DT_W-1:0] DT_RESET = DT_W'(167772);

  // Shared multiplier and the intermediate registers.
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  // Widest intermediate is dt*h >> FRAC_W, below 2^50.
  localparam int FX_W   = 51;
  // Accumulator for two-word products: dt*h stays below 2^74.
  localparam int ACC_W  = 75;

  // Register indexes on the configuration port.
  localparam logic REG_SUPPLY_RATE = 1'b0;
  localparam logic REG_STEP_SIZE   = 1'b1;

  // Microprogram counter.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_FIRST = PC_W'(0);
  localparam logic [PC_W-1:0] PC_LOAD  = PC_W'(11);

  typedef enum logic [1:0] {
    A_X,
    A_DT,
    A_SQ_LO,
    A_SQ_HI
  } asel_t;

  typedef enum logic [2:0] {
    B_X,
    B_Y,
    B_NU,
    B_H_LO,
    B_H_HI
  } bsel_t;

  typedef enum logic [3:0] {
    P_NONE,
    P_SQ,
    P_NX,
    P_PY,
    P_ACC_HY,
    P_ACC,
    P_H,
    P_PX,
    P_DIFF,
    P_SETTLE,
    P_LOAD
  } post_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_LOAD,
    BR_DONE
  } br_t;

  // One control word: multiplier operands for the product issued this
  // cycle, what to do with the product issued the cycle before, and the
  // sequencing action.
  typedef struct packed {
    asel_t a_sel;
    bsel_t b_sel;
    post_t post;
    br_t   br;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{a_sel: A_X, b_sel: B_X, post: P_NONE, br: BR_NEXT};

  // Result of the final step of a request.
  typedef struct packed {
    logic [VALUE_W-1:0] x;
    logic [VALUE_W-1:0] y;
    logic               sat;
  } res_t;

  // Microprogram. Steps 0 to 10 form one Euler step, step 11 is a load.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CTRL_NOP;
    case (pc)
      PC_W'(0): begin
        w.a_sel = A_X;     w.b_sel = B_X;    w.br = BR_LOAD;
      end
      PC_W'(1): begin
        w.a_sel = A_DT;    w.b_sel = B_X;    w.post = P_SQ;
      end
      PC_W'(2): begin
        w.a_sel = A_DT;    w.b_sel = B_NU;   w.post = P_NX;
      end
      PC_W'(3): begin
        w.a_sel = A_SQ_LO; w.b_sel = B_Y;    w.post = P_PY;
      end
      PC_W'(4): begin
        w.a_sel = A_SQ_HI; w.b_sel = B_Y;    w.post = P_ACC_HY;
      end
      PC_W'(5): begin
        w.post = P_H;
      end
      PC_W'(6): begin
        w.a_sel = A_DT;    w.b_sel = B_H_LO;
      end
      PC_W'(7): begin
        w.a_sel = A_DT;    w.b_sel = B_H_HI; w.post = P_ACC;
      end
      PC_W'(8): begin
        w.post = P_PX;
      end
      PC_W'(9): begin
        w.post = P_DIFF;
      end
      PC_W'(10): begin
        w.post = P_SETTLE; w.br = BR_DONE;
      end
      PC_LOAD: begin
        w.post = P_LOAD;   w.br = BR_DONE;
      end
      default: begin
        w.br = BR_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/gose_sequencer.sv */
// ----------------------------------------------------------------------------
// gose_sequencer
// Program counter and control store; holds on a result step until the output
// register can take the result.
// ----------------------------------------------------------------------------
module gose_sequencer
  import gose_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  op_load,
  input  logic  out_free,
  output ctrl_t ctrl,
  output logic  busy
);

  logic [PC_W-1:0] pc;
  ctrl_t           word;
  logic            hold;

  assign word = ucode(pc);
  // A result step waits while the output register is still occupied.
  assign hold = ((word.post == P_SETTLE) || (word.post == P_LOAD)) && !out_free;
  assign ctrl = (busy && !hold) ? word : CTRL_NOP;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_FIRST;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= PC_FIRST;
    end else if (busy && !hold) begin
      case (word.br)
        BR_NEXT: pc <= pc + PC_W'(1);
        BR_LOAD: pc <= op_load ? PC_LOAD : pc + PC_W'(1);
        BR_DONE: busy <= 1'b0;
        default: busy <= 1'b0;
      endcase
    end
  end

endmodule

/* sv/gose_datapath.sv */
// ----------------------------------------------------------------------------
// gose_datapath
// Shared 32x32 multiplier, two-word accumulator, intermediate registers and
// the clamping update of the two concentrations.
// ----------------------------------------------------------------------------
module gose_datapath
  import gose_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ctrl_t              ctrl,
  input  logic [VALUE_W-1:0] load_x,
  input  logic [VALUE_W-1:0] load_y,
  input  logic [NU_W-1:0]    supply_rate,
  input  logic [DT_W-1:0]    step_size,
  output res_t               res
);

  localparam int SUM_W = FX_W + 2;
  localparam logic [VALUE_W-1:0] VMAX = '1;

  logic [VALUE_W-1:0]      x;
  logic [VALUE_W-1:0]      y;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic [PROD_W-1:0]       prod;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        acc_sum;
  logic [FX_W-1:0]         prod_fx;
  logic [FX_W-1:0]         sq;
  logic [FX_W-1:0]         nx;
  logic [FX_W-1:0]         py;
  logic [FX_W-1:0]         h;
  logic [FX_W-1:0]         px;
  logic signed [FX_W:0]    dx;
  logic signed [FX_W:0]    dy;
  logic [VALUE_W-1:0]      x_next;
  logic [VALUE_W-1:0]      y_next;
  logic                    sat_x;
  logic                    sat_y;

  // v + d clamped to [0, VMAX]; sat flags the top clamp.
  function automatic logic [VALUE_W:0] settle(input logic [VALUE_W-1:0] v,
                                               input logic signed [FX_W:0] d);
    logic signed [SUM_W-1:0] s;
    logic [VALUE_W:0]        r;
    s = $signed({{(SUM_W-VALUE_W){1'b0}}, v}) + SUM_W'(d);
    if (s < 0) begin
      r = '0;
    end else if (s > $signed({{(SUM_W-VALUE_W){1'b0}}, VMAX})) begin
      r = {1'b1, VMAX};
    end else begin
      r = {1'b0, s[VALUE_W-1:0]};
    end
    return r;
  endfunction

  always_comb begin
    case (ctrl.a_sel)
      A_X:     mul_a = x;
      A_DT:    mul_a = MUL_W'(step_size);
      A_SQ_LO: mul_a = sq[MUL_W-1:0];
      A_SQ_HI: mul_a = MUL_W'(sq[FX_W-1:MUL_W]);
      default: mul_a = '0;
    endcase
    case (ctrl.b_sel)
      B_X:     mul_b = x;
      B_Y:     mul_b = y;
      B_NU:    mul_b = MUL_W'(supply_rate);
      B_H_LO:  mul_b = h[MUL_W-1:0];
      B_H_HI:  mul_b = MUL_W'(h[FX_W-1:MUL_W]);
      default: mul_b = '0;
    endcase
  end

  assign prod_fx = FX_W'(prod >> FRAC_W);
  assign acc_sum = acc + (ACC_W'(prod) << MUL_W);

  assign {sat_x, x_next} = settle(x, dx);
  assign {sat_y, y_next} = settle(y, dy);

  always_comb begin
    if (ctrl.post == P_LOAD) begin
      res.x   = load_x;
      res.y   = load_y;
      res.sat = 1'b0;
    end else begin
      res.x   = x_next;
      res.y   = y_next;
      res.sat = sat_x | sat_y;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (ctrl.post)
      P_SQ:     sq  <= prod_fx;
      P_NX:     nx  <= prod_fx;
      P_PY:     py  <= prod_fx;
      P_ACC_HY: acc <= ACC_W'(prod) + (ACC_W'(y >> 1) << FRAC_W);
      P_ACC:    acc <= ACC_W'(prod);
      P_H:      h   <= FX_W'(acc_sum >> FRAC_W);
      P_PX:     px  <= FX_W'(acc_sum >> FRAC_W);
      P_DIFF: begin
        dx <= $signed({1'b0, px}) - $signed({1'b0, nx});
        dy <= $signed({1'b0, py}) - $signed({1'b0, px});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
      y <= '0;
    end else if (ctrl.post == P_LOAD) begin
      x <= load_x;
      y <= load_y;
    end else if (ctrl.post == P_SETTLE) begin
      x <= x_next;
      y <= y_next;
    end
  end

endmodule

/* sv/glycolysis_oscillator_euler_stepper_unit.sv */
// ----------------------------------------------------------------------------
// glycolysis_oscillator_euler_stepper_unit
// Forward-Euler integrator of the two-variable glycolysis oscillator in
// unsigned Q8.24 fixed point, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// A load request sets x and y and restarts the step count; a step request
// advances both by dx = -x + y/2 + x*x*y and dy = nu - y/2 - x*x*y times dt,
// clamps at zero and at full scale, and returns one result per request. A
// request runs through a short microprogram on one shared 32x32 multiplier:
// a step takes eleven control steps because it needs seven dependent partial
// products (x*x, two words of x*x*y, dt*x, dt*nu, two words of dt*h) plus a
// difference and a clamping step; a load takes two control steps. No new
// request is taken while one is still running through the microprogram.
// The result register sits between the sequencer and the output, so
// a new request is taken while a finished result waits; the sequencer only
// holds on its final step if the previous result has not yet been taken.
// The report flag marks every REPORT_INTERVAL-th step. The two configuration
// registers (supply_rate at byte address 0, step_size at 4) may only be
// written while no request is in flight.
// ----------------------------------------------------------------------------
module glycolysis_oscillator_euler_stepper_unit
  import gose_pkg::*;
#(
  parameter int REPORT_INTERVAL = REPORT_INTERVAL_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [31:0] init_x,
  input  logic [31:0] init_y,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] conc_x,
  output logic [31:0] conc_y,
  output logic [31:0] step_index,
  output logic        report,
  output logic        saturated,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Width of the counter that tracks the step index modulo REPORT_INTERVAL.
  localparam int RPT_W = (REPORT_INTERVAL > 1) ? $clog2(REPORT_INTERVAL) : 1;
  localparam logic [RPT_W-1:0] RPT_LAST = RPT_W'(REPORT_INTERVAL - 1);

  logic [NU_W-1:0]    supply_rate;
  logic [DT_W-1:0]    step_size;
  logic               cfg_write;

  logic               in_accept;
  logic               op_load;
  logic [VALUE_W-1:0] load_x;
  logic [VALUE_W-1:0] load_y;

  ctrl_t              ctrl;
  logic               busy;
  logic               out_free;
  logic               emit;
  res_t               res;

  logic [31:0]        step_count;
  logic [RPT_W-1:0]   rpt_cnt;

  // Configuration port: zero-wait writes, reads straight from the registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_STEP_SIZE) ? 32'(step_size) : 32'(supply_rate);

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_rate <= NU_RESET;
      step_size   <= DT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SUPPLY_RATE) begin
        supply_rate <= pwdata[NU_W-1:0];
      end else begin
        step_size <= pwdata[DT_W-1:0];
      end
    end
  end

  // The request is captured at acceptance and stays put while the
  // microprogram runs.
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_load <= (operation == OP_LOAD);
      load_x  <= VALUE_W'(init_x);
      load_y  <= VALUE_W'(init_y);
    end
  end

  // The output register is free when empty or being emptied this cycle.
  assign out_free = !out_valid || !out_stall;

  gose_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept),
    .op_load  (op_load),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  gose_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .load_x      (load_x),
    .load_y      (load_y),
    .supply_rate (supply_rate),
    .step_size   (step_size),
    .res         (res)
  );

  // The sequencer only issues a result step when the output register is free.
  assign emit = (ctrl.post == P_SETTLE) || (ctrl.post == P_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      step_count <= '0;
      rpt_cnt    <= '0;
    end else if (emit) begin
      out_valid <= 1'b1;
      conc_x    <= 32'(res.x);
      conc_y    <= 32'(res.y);
      saturated <= res.sat;
      if (ctrl.post == P_LOAD) begin
        step_index <= '0;
        report     <= 1'b0;
        step_count <= '0;
        rpt_cnt    <= '0;
      end else begin
        step_index <= step_count;
        report     <= (rpt_cnt == '0);
        step_count <= step_count + 32'd1;
        // The index wraps to zero, which is a report step again.
        if ((step_count == '1) || (rpt_cnt == RPT_LAST)) begin
          rpt_cnt <= '0;
        end else begin
          rpt_cnt <= rpt_cnt + RPT_W'(1);
        end
      end
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // An accepted request always starts the microprogram.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> busy)
    else $error("accepted request did not start the sequencer");

  // A result appears only as the end of a running microprogram.
  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy))
    else $error("result produced without a running request");

  // The saturation flag means one of the values sits at full scale.
  a_sat_at_top: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> ((conc_x == '1) || (conc_y == '1)))
    else $error("saturated flag without a value at full scale");
`endif

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the glycolysis oscillator Euler stepper against a cycle-free model
// of its fixed-point arithmetic: directed loads and steps at the extremes,
// register settings at their limits, then random load-and-step runs with
// random idling on both channels.
// ----------------------------------------------------------------------------
module testbench
  import gose_pkg::*;
();

  // Largest concentration the block can hold.
  localparam logic [63:0] FULL_SCALE = (64'd1 << VALUE_W) - 64'd1;

  // One expected result, in the order of the result ports.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] step_no;
    logic        report;
    logic        saturated;
  } conc_result_t;

  // Clock and reset. Reset is held at the start and never asserted again.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every block input starts at a known value.
  logic        in_valid  = 1'b0;
  logic        operation = OP_LOAD;
  logic [31:0] init_x    = '0;
  logic [31:0] init_y    = '0;
  logic        out_stall = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;

  logic        in_stall;
  logic        out_valid;
  logic [31:0] conc_x;
  logic [31:0] conc_y;
  logic [31:0] step_index;
  logic        report;
  logic        saturated;
  logic [31:0] prdata;
  logic        pready;

  glycolysis_oscillator_euler_stepper_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .init_x     (init_x),
    .init_y     (init_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .conc_x     (conc_x),
    .conc_y     (conc_y),
    .step_index (step_index),
    .report     (report),
    .saturated  (saturated),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Our own copy of the oscillator state and of the two registers.
  logic [31:0]     osc_x = '0;
  logic [31:0]     osc_y = '0;
  logic [31:0]     steps_since_load = '0;
  logic [NU_W-1:0] supply_rate_now = NU_RESET;
  logic [DT_W-1:0] step_size_now   = DT_RESET;

  // Results still owed by the block, oldest first.
  conc_result_t pending_conc[$];

  // Idling controls: the sender gaps and the receiver stalls only when enabled.
  bit idle_on  = 1'b0;
  bit stall_on = 1'b0;
  // Mirrors the last value driven onto in_valid, so it is never driven twice
  // in one time step.
  bit request_up = 1'b0;

  int requests_sent   = 0;
  int loads_sent      = 0;
  int results_checked = 0;
  int writes_done     = 0;
  int reports_seen    = 0;
  int saturations_seen = 0;
  int mismatches      = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the stepper.
  // ---------------------------------------------------------------------------

  // (a*b) >> FRAC_W, saturating at 2^64-1.
  function automatic logic [63:0] fixed_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> FRAC_W;
    return (p[127:64] != '0) ? '1 : p[63:0];
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Applies v + gain - loss, clamped to zero below and full scale above. The
  // top bit of the return value tells that the upper clamp acted.
  function automatic logic [32:0] settle_conc(input logic [63:0] v, input logic [63:0] gain,
                                              input logic [63:0] loss);
    logic [63:0] r;
    if (gain >= loss) begin
      r = add_sat(v, gain - loss);
    end else begin
      r = (loss - gain >= v) ? 64'd0 : v - (loss - gain);
    end
    if (r > FULL_SCALE) begin
      return {1'b1, FULL_SCALE[31:0]};
    end
    return {1'b0, r[31:0]};
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic conc_result_t advance_oscillator(input logic op, input logic [31:0] ix,
                                                      input logic [31:0] iy);
    conc_result_t r;
    logic [63:0] sq, q, h, px, nx, py;
    logic [32:0] sx, sy;
    r = '0;
    if (op == OP_LOAD) begin
      osc_x = ix;
      osc_y = iy;
      steps_since_load = '0;
    end else begin
      sq = fixed_mul({32'd0, osc_x}, {32'd0, osc_x});
      q  = fixed_mul(sq, {32'd0, osc_y});
      h  = add_sat({32'd0, osc_y} >> 1, q);
      px = fixed_mul(64'(step_size_now), h);
      nx = fixed_mul(64'(step_size_now), {32'd0, osc_x});
      py = fixed_mul(64'(step_size_now), 64'(supply_rate_now));
      // Both updates use the old x and y; x loses dt*x, y loses what x gains.
      sx = settle_conc({32'd0, osc_x}, px, nx);
      sy = settle_conc({32'd0, osc_y}, py, px);
      osc_x = sx[31:0];
      osc_y = sy[31:0];
      r.step_no   = steps_since_load;
      r.report    = (steps_since_load % 32'(REPORT_INTERVAL_DEF)) == 32'd0;
      r.saturated = sx[32] | sy[32];
      steps_since_load = steps_since_load + 32'd1;
    end
    r.x = osc_x;
    r.y = osc_y;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  // Sends one request and records what it must produce at the edge that
  // accepts it. Valid stays high afterwards; the next request either reuses
  // it at once or drops it for a gap.
  task automatic send_request(input logic op, input logic [31:0] ix, input logic [31:0] iy);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      if (request_up) begin
        in_valid <= 1'b0;
        request_up = 1'b0;
      end
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    request_up = 1'b1;
    operation <= op;
    init_x    <= ix;
    init_y    <= iy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_conc.push_back(advance_oscillator(op, ix, iy));
    requests_sent++;
    if (op == OP_LOAD) loads_sent++;
  endtask

  // Drops valid and waits until every owed result has come back, which
  // leaves the block idle.
  task automatic wait_results_drained();
    if (request_up) begin
      in_valid <= 1'b0;
      request_up = 1'b0;
    end
    while (pending_conc.size() != 0) @(posedge clk);
  endtask

  // Writes one register over the configuration port, only once the block has
  // gone idle. The register takes the value at the edge that ends the access
  // cycle.
  task automatic write_register(input logic idx, input logic [31:0] value);
    wait_results_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SUPPLY_RATE) begin
      supply_rate_now = value[NU_W-1:0];
    end else begin
      step_size_now = value[DT_W-1:0];
    end
    writes_done++;
  endtask

  // Concentrations mostly in the oscillating range up to 4.0, sometimes zero
  // or anywhere in the full 32 bits.
  function automatic logic [31:0] pick_conc();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'd0;
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_supply_rate();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h0FFF_FFFF;
      2: return 32'(NU_RESET);
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_step_size();
    case ($urandom_range(0, 5))
      0: return 32'd1;
      1: return 32'h0100_0000;
      2: return 32'(DT_RESET);
      3: return $urandom_range(1, 32'h0100_0000);
      default: return $urandom_range(1, 32'h0040_0000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts and the field-by-field check.
  // ---------------------------------------------------------------------------

  always begin
    @(posedge clk);
    if (stall_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    conc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_conc.size() == 0) begin
        $error("result with no request outstanding: conc_x %h conc_y %h step_index %h",
               conc_x, conc_y, step_index);
        mismatches++;
      end else begin
        want = pending_conc.pop_front();
        compare_field("conc_x", want.x, conc_x);
        compare_field("conc_y", want.y, conc_y);
        compare_field("step_index", want.step_no, step_index);
        compare_field("report", 32'(want.report), 32'(report));
        compare_field("saturated", 32'(want.saturated), 32'(saturated));
        results_checked++;
        if (want.report) reports_seen++;
        if (want.saturated) saturations_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Steps straight out of reset: x and y start at zero, so only the supply
  // term moves y.
  task automatic test_reset_state();
    send_request(OP_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_STEP, 32'd0, 32'd0);
  endtask

  // Loads at the corners of the field ranges. Full-scale x and y blow up
  // x*x*y, drive x into the top clamp and push y down to zero.
  task automatic test_load_extremes();
    send_request(OP_LOAD, 32'd0, 32'd0);
    send_request(OP_STEP, 32'd0, 32'd0);
    send_request(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_STEP, 32'd0, 32'd0);
    send_request(OP_STEP, 32'd0, 32'd0);
    send_request(OP_LOAD, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_STEP, 32'd0, 32'd0);
    send_request(OP_LOAD, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_STEP, 32'd0, 32'd0);
  endtask

  // Register limits: a zero step leaves x and y alone; a unit step with no
  // supply pushes y below zero and then x exactly to zero; all-ones writes
  // check that only the register's own bits are kept, with dt above 1.0.
  task automatic test_register_extremes();
    write_register(REG_STEP_SIZE, 32'd0);
    send_request(OP_LOAD, 32'h0280_0000, 32'h0180_0000);
    send_request(OP_STEP, 32'd0, 32'd0);
    write_register(REG_STEP_SIZE, 32'h0100_0000);
    write_register(REG_SUPPLY_RATE, 32'd0);
    send_request(OP_LOAD, 32'h0200_0000, 32'h0100_0000);
    send_request(OP_STEP, 32'd0, 32'd0);
    send_request(OP_STEP, 32'd0, 32'd0);
    write_register(REG_SUPPLY_RATE, 32'hFFFF_FFFF);
    write_register(REG_STEP_SIZE, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 32'd0, 32'd0);
    send_request(OP_STEP, 32'd0, 32'd0);
    send_request(OP_STEP, 32'd0, 32'd0);
    write_register(REG_STEP_SIZE, 32'd1);
    send_request(OP_STEP, 32'd0, 32'd0);
    write_register(REG_SUPPLY_RATE, 32'(NU_RESET));
    write_register(REG_STEP_SIZE, 32'(DT_RESET));
  endtask

  // Runs of a load followed by steps, with random settings between runs. A few
  // runs continue from the previous state without a load, and stray loads with
  // arbitrary values break some runs. One long run crosses several report
  // points. Each run ends with the sender waiting for every result.
  task automatic test_random_runs();
    int run_no;
    int run_len;
    run_no = 0;
    while (requests_sent < 700) begin
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if (run_no == 3) begin
        write_register(REG_SUPPLY_RATE, 32'(NU_RESET));
        write_register(REG_STEP_SIZE, 32'h0020_0000);
      end else if ($urandom_range(0, 2) == 0) begin
        write_register(REG_SUPPLY_RATE, pick_supply_rate());
        write_register(REG_STEP_SIZE, pick_step_size());
      end
      if (run_no % 8 != 5) send_request(OP_LOAD, pick_conc(), pick_conc());
      run_len = (run_no == 3) ? 230 : $urandom_range(1, 40);
      repeat (run_len) begin
        if (run_no != 3 && $urandom_range(0, 19) == 0) begin
          send_request(OP_LOAD, $urandom, $urandom);
        end else begin
          send_request(OP_STEP, $urandom, $urandom);
        end
      end
      wait_results_drained();
      run_no++;
    end
  endtask

  // Back-to-back requests with no idling on either side.
  task automatic test_steady_tail();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    send_request(OP_LOAD, pick_conc(), pick_conc());
    repeat (50) send_request(OP_STEP, $urandom, $urandom);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on  = 1'b1;
    stall_on = 1'b1;
    test_reset_state();
    test_load_extremes();
    test_register_extremes();
    test_random_runs();
    test_steady_tail();
    wait_results_drained();
    // Any result arriving during this wait is unowed.
    repeat (40) @(posedge clk);
    $display("Sent %0d requests (%0d loads), checked %0d results, %0d register writes.",
             requests_sent, loads_sent, results_checked, writes_done);
    $display("Results with report set: %0d, with saturation set: %0d.",
             reports_seen, saturations_seen);
    if (mismatches == 0 && pending_conc.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
